// ===== src/cse_pkg.sv =====
// Shared types, constants and kernel arithmetic for the compass Sobel edge block.
package cse_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 13;
    localparam int IDX_W      = 8;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int NUM_TAPS   = 9;
    localparam int NUM_KERNELS = 4;
    localparam int ACC_W      = 12;
    localparam int TQ_DEPTH   = 4;
    localparam int TQ_PTR_W   = $clog2(TQ_DEPTH);
    localparam int TQ_CNT_W   = $clog2(TQ_DEPTH + 1);
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [CFG_W-1:0] DIM_MIN            = 13'd3;

    typedef enum logic [IDX_W-1:0] {
        REG_LINE_WIDTH   = 8'd0,
        REG_FRAME_HEIGHT = 8'd1
    } reg_index_t;

    localparam logic signed [2:0] KERNELS [NUM_KERNELS][NUM_TAPS] = '{
        '{-3'sd1, -3'sd2, -3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd2,  3'sd1},
        '{-3'sd1,  3'sd0,  3'sd1, -3'sd2,  3'sd0,  3'sd2, -3'sd1,  3'sd0,  3'sd1},
        '{ 3'sd2,  3'sd1,  3'sd0,  3'sd1,  3'sd0, -3'sd1,  3'sd0, -3'sd1, -3'sd2},
        '{ 3'sd0,  3'sd1,  3'sd2, -3'sd1,  3'sd0,  3'sd1, -3'sd2, -3'sd1,  3'sd0}
    };

    typedef struct packed {
        logic [CFG_W-1:0] line_width;
        logic [CFG_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_rgb;
        logic             start_of_frame;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_rgb;
        logic             last_in_row;
        logic             last_of_frame;
    } edge_out_t;

    typedef struct packed {
        logic [NUM_TAPS-1:0][PIX_W-1:0] taps;
        logic                           row_end;
        logic                           frame_end;
    } tap_item_t;

    function automatic logic signed [ACC_W-1:0] kernel_response(
        input logic [NUM_TAPS-1:0][CH_W-1:0] px,
        input logic [1:0]                    k
    );
        logic signed [ACC_W-1:0] acc;
        acc = '0;
        for (int t = 0; t < NUM_TAPS; t++)
        begin
            acc = acc + ACC_W'(KERNELS[k][t]) * $signed({4'b0000, px[t]});
        end
        return acc;
    endfunction

endpackage

// ===== src/cse_front.sv =====
// Front end: position counters, line stores, 3x3 window and border classification.
module cse_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cse_pkg::cfg_t                 cfg,
    input  logic                          push,
    output logic                          full,
    input  cse_pkg::pixel_in_t            sample,
    input  logic [cse_pkg::TQ_CNT_W-1:0]  tq_count,
    output logic                          tq_push,
    output cse_pkg::tap_item_t            tq_data
);

    logic [cse_pkg::PIX_W-1:0] older_mem [cse_pkg::MAX_WIDTH];
    logic [cse_pkg::PIX_W-1:0] newer_mem [cse_pkg::MAX_WIDTH];

    logic [cse_pkg::COL_W-1:0] col_reg, col_next;
    logic [cse_pkg::ROW_W-1:0] row_reg, row_next;
    logic [cse_pkg::COL_W-1:0] col_eff;
    logic [cse_pkg::ROW_W-1:0] row_eff;
    logic [cse_pkg::CFG_W-1:0] w_use, h_use;
    logic                      accept, row_end_a, frame_end_a, produce_a, fwd_hit;

    logic                      b_valid_reg;
    logic [cse_pkg::PIX_W-1:0] b_pixel_reg;
    logic [cse_pkg::COL_W-1:0] b_col_reg;
    logic                      b_produce_reg, b_row_end_reg, b_frame_end_reg;
    logic [cse_pkg::PIX_W-1:0] older_rd_reg, newer_rd_reg;
    logic                      fwd_reg;
    logic [cse_pkg::PIX_W-1:0] fwd_top_reg, fwd_mid_reg;
    logic [cse_pkg::PIX_W-1:0] b_top, b_mid;
    logic [cse_pkg::PIX_W-1:0] win_reg [6];

    always_comb
    begin
        if (cfg.line_width < cse_pkg::DIM_MIN)
            w_use = cse_pkg::DIM_MIN;
        else if (cfg.line_width > cse_pkg::CFG_W'(cse_pkg::MAX_WIDTH))
            w_use = cse_pkg::CFG_W'(cse_pkg::MAX_WIDTH);
        else
            w_use = cfg.line_width;
        if (cfg.frame_height < cse_pkg::DIM_MIN)
            h_use = cse_pkg::DIM_MIN;
        else if (cfg.frame_height > cse_pkg::CFG_W'(cse_pkg::MAX_HEIGHT))
            h_use = cse_pkg::CFG_W'(cse_pkg::MAX_HEIGHT);
        else
            h_use = cfg.frame_height;
    end

    assign full = (tq_count + cse_pkg::TQ_CNT_W'(b_valid_reg && b_produce_reg))
                  >= cse_pkg::TQ_CNT_W'(cse_pkg::TQ_DEPTH);
    assign accept  = push && !full;
    assign col_eff = sample.start_of_frame ? '0 : col_reg;
    assign row_eff = sample.start_of_frame ? '0 : row_reg;

    assign row_end_a   = {1'b0, col_eff} >= (w_use - 1'b1);
    assign frame_end_a = row_end_a && ({1'b0, row_eff} >= (h_use - 1'b1));
    assign produce_a   = (row_eff >= cse_pkg::ROW_W'(2)) && (col_eff >= cse_pkg::COL_W'(2));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end_a)
            begin
                col_next = '0;
                row_next = frame_end_a ? '0 : row_eff + 1'b1;
            end
            else
            begin
                col_next = col_eff + 1'b1;
                row_next = row_eff;
            end
        end
    end

    assign b_top   = fwd_reg ? fwd_top_reg : older_rd_reg;
    assign b_mid   = fwd_reg ? fwd_mid_reg : newer_rd_reg;
    assign fwd_hit = b_valid_reg && (b_col_reg == col_eff);

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            older_mem[b_col_reg] <= b_mid;
            newer_mem[b_col_reg] <= b_pixel_reg;
        end
        if (accept)
        begin
            older_rd_reg    <= older_mem[col_eff];
            newer_rd_reg    <= newer_mem[col_eff];
            fwd_top_reg     <= b_mid;
            fwd_mid_reg     <= b_pixel_reg;
            b_pixel_reg     <= sample.pixel_rgb;
            b_col_reg       <= col_eff;
            b_row_end_reg   <= row_end_a;
            b_frame_end_reg <= frame_end_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            b_valid_reg   <= 1'b0;
            b_produce_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= accept;
            if (accept)
            begin
                b_produce_reg <= produce_a;
                fwd_reg       <= fwd_hit;
            end
            if (b_valid_reg)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= b_top;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= b_mid;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= b_pixel_reg;
            end
        end
    end

    assign tq_push           = b_valid_reg && b_produce_reg;
    assign tq_data.taps[0]   = win_reg[0];
    assign tq_data.taps[1]   = win_reg[1];
    assign tq_data.taps[2]   = b_top;
    assign tq_data.taps[3]   = win_reg[2];
    assign tq_data.taps[4]   = win_reg[3];
    assign tq_data.taps[5]   = b_mid;
    assign tq_data.taps[6]   = win_reg[4];
    assign tq_data.taps[7]   = win_reg[5];
    assign tq_data.taps[8]   = b_pixel_reg;
    assign tq_data.row_end   = b_row_end_reg;
    assign tq_data.frame_end = b_frame_end_reg;

    a_last_col_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && (&b_col_reg)) |-> b_row_end_reg)
        else $error("last column did not end the row");

    a_no_frame_end_midrow: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_frame_end_reg) |-> b_row_end_reg)
        else $error("frame end without row end");

endmodule

// ===== src/cse_tap_queue.sv =====
// Short queue of tap windows between the front end and the kernel datapath.
module cse_tap_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  cse_pkg::tap_item_t            push_data,
    input  logic                          pop,
    output cse_pkg::tap_item_t            head,
    output logic                          empty,
    output logic [cse_pkg::TQ_CNT_W-1:0]  count
);

    cse_pkg::tap_item_t              mem [cse_pkg::TQ_DEPTH];
    logic [cse_pkg::TQ_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [cse_pkg::TQ_CNT_W-1:0]    count_reg, count_next;

    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != cse_pkg::TQ_CNT_W'(cse_pkg::TQ_DEPTH)))
        else $error("tap queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("tap queue underflow");

endmodule

// ===== src/cse_back.sv =====
// Back end: compass kernels, magnitude and maximum per channel, result queue.
module cse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tq_empty,
    input  cse_pkg::tap_item_t  tq_head,
    output logic                tq_pop,
    input  logic                pop,
    output logic                empty,
    output cse_pkg::edge_out_t  result
);

    logic signed [cse_pkg::ACC_W-1:0] acc_reg  [cse_pkg::NUM_CH][cse_pkg::NUM_KERNELS];
    logic signed [cse_pkg::ACC_W-1:0] acc_next [cse_pkg::NUM_CH][cse_pkg::NUM_KERNELS];
    logic                             s1_valid_reg, s1_row_end_reg, s1_frame_end_reg;
    cse_pkg::edge_out_t               s2_item;

    cse_pkg::edge_out_t               oq_mem [cse_pkg::OQ_DEPTH];
    logic [cse_pkg::OQ_PTR_W-1:0]     oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [cse_pkg::OQ_CNT_W-1:0]     oq_count_reg, oq_count_next;
    logic                             oq_pop;

    assign tq_pop = !tq_empty &&
        ((oq_count_reg + cse_pkg::OQ_CNT_W'(s1_valid_reg))
         < cse_pkg::OQ_CNT_W'(cse_pkg::OQ_DEPTH));

    always_comb
    begin
        logic [cse_pkg::NUM_TAPS-1:0][cse_pkg::CH_W-1:0] px;
        for (int c = 0; c < cse_pkg::NUM_CH; c++)
        begin
            for (int t = 0; t < cse_pkg::NUM_TAPS; t++)
            begin
                px[t] = tq_head.taps[t][c*cse_pkg::CH_W +: cse_pkg::CH_W];
            end
            for (int k = 0; k < cse_pkg::NUM_KERNELS; k++)
            begin
                acc_next[c][k] = cse_pkg::kernel_response(px, 2'(k));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tq_pop)
        begin
            acc_reg          <= acc_next;
            s1_row_end_reg   <= tq_head.row_end;
            s1_frame_end_reg <= tq_head.frame_end;
        end
    end

    always_comb
    begin
        logic [cse_pkg::ACC_W-1:0] mag;
        logic [cse_pkg::ACC_W-1:0] best;
        s2_item.edge_rgb = '0;
        for (int c = 0; c < cse_pkg::NUM_CH; c++)
        begin
            best = '0;
            for (int k = 0; k < cse_pkg::NUM_KERNELS; k++)
            begin
                mag = acc_reg[c][k][cse_pkg::ACC_W-1] ? -acc_reg[c][k] : acc_reg[c][k];
                if (mag > best)
                    best = mag;
            end
            s2_item.edge_rgb[c*cse_pkg::CH_W +: cse_pkg::CH_W] =
                (best > cse_pkg::ACC_W'(255)) ? 8'hFF : best[cse_pkg::CH_W-1:0];
        end
        s2_item.last_in_row   = s1_row_end_reg;
        s2_item.last_of_frame = s1_frame_end_reg;
    end

    assign oq_pop = pop && (oq_count_reg != '0);
    assign empty  = (oq_count_reg == '0);
    assign result = oq_mem[oq_rd_ptr_reg];

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (s1_valid_reg && !oq_pop)
            oq_count_next = oq_count_reg + 1'b1;
        else if (oq_pop && !s1_valid_reg)
            oq_count_next = oq_count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            oq_mem[oq_wr_ptr_reg] <= s2_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= tq_pop;
            if (s1_valid_reg)
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            if (oq_pop)
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            oq_count_reg <= oq_count_next;
        end
    end

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (oq_count_reg != cse_pkg::OQ_CNT_W'(cse_pkg::OQ_DEPTH)))
        else $error("result queue overflow");

endmodule

// ===== src/compass_sobel_edge_rgb_top.sv =====
// A pixel's result, if any, passes front-end regs, tap queue, kernel regs and result queue.
// Throughput: one pixel per cycle unless full; set by the front end's single line store port pair.
// Results drain at one per cycle while pop is high; full rises only when both internal queues back up.
// Reset: rst_n asynchronous, active low; clears counters, window, queues and config
// (line_width 640, frame_height 480). Line stores are not cleared, no sweep after reset.
module compass_sobel_edge_rgb_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  cse_pkg::pixel_in_t            sample,
    output logic                          empty,
    input  logic                          pop,
    output cse_pkg::edge_out_t            result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cse_pkg::IDX_W-1:0]     cfg_index,
    input  logic [cse_pkg::CFG_W-1:0]     cfg_data
);

    logic [cse_pkg::CFG_W-1:0]     line_width_reg, line_width_next;
    logic [cse_pkg::CFG_W-1:0]     frame_height_reg, frame_height_next;
    cse_pkg::cfg_t                 cfg;
    logic                          tq_push, tq_pop, tq_empty;
    cse_pkg::tap_item_t            tq_in, tq_head;
    logic [cse_pkg::TQ_CNT_W-1:0]  tq_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                cse_pkg::REG_LINE_WIDTH:   line_width_next   = cfg_data;
                cse_pkg::REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= cse_pkg::LINE_WIDTH_RESET;
            frame_height_reg <= cse_pkg::FRAME_HEIGHT_RESET;
        end
        else
        begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    assign cfg.line_width   = line_width_reg;
    assign cfg.frame_height = frame_height_reg;

    cse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .full     (full),
        .sample   (sample),
        .tq_count (tq_count),
        .tq_push  (tq_push),
        .tq_data  (tq_in)
    );

    cse_tap_queue u_tap_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tq_push),
        .push_data (tq_in),
        .pop       (tq_pop),
        .head      (tq_head),
        .empty     (tq_empty),
        .count     (tq_count)
    );

    cse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .tq_empty (tq_empty),
        .tq_head  (tq_head),
        .tq_pop   (tq_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

// ===== tb/tb_compass_sobel_edge_rgb_top.sv =====
// Self-checking testbench for the compass Sobel edge block: directed frames, random frames, large sizes.
module tb_compass_sobel_edge_rgb_top;

    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int SETTLE_TICKS = 8;
    localparam int RAND_PIXELS  = 950;
    localparam int NUM_DIRECTED = 27;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_VALUE
    } check_kind_t;

    typedef struct packed {
        logic [cse_pkg::PIX_W-1:0] px;
        logic                      sof;
        check_kind_t               kind;
        logic [cse_pkg::PIX_W-1:0] want_rgb;
        logic                      want_row;
        logic                      want_frame;
    } directed_row_t;

    localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
        '{24'hFFFFFF, 1'b1, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_VALUE, 24'h000000, 1'b1, 1'b1},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h010203, 1'b0, CHK_VALUE, 24'h020406, 1'b1, 1'b1},
        '{24'hFFFFFF, 1'b1, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'hFFFFFF, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_NONE,  24'h000000, 1'b0, 1'b0},
        '{24'h000000, 1'b0, CHK_VALUE, 24'hFFFFFF, 1'b1, 1'b1}
    };

    localparam int COMPASS_K [4][9] = '{
        '{-1, -2, -1,  0,  0,  0,  1,  2,  1},
        '{-1,  0,  1, -2,  0,  2, -1,  0,  1},
        '{ 2,  1,  0,  1,  0, -1,  0, -1, -2},
        '{ 0,  1,  2, -1,  0,  1, -2, -1,  0}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      push      = 1'b0;
    cse_pkg::pixel_in_t        sample    = '0;
    logic                      pop       = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [cse_pkg::IDX_W-1:0] cfg_index = '0;
    logic [cse_pkg::CFG_W-1:0] cfg_data  = '0;
    logic                      full;
    logic                      empty;
    logic                      cfg_ready;
    cse_pkg::edge_out_t        result;

    check_kind_t        cur_kind = CHK_PREDICT;
    cse_pkg::edge_out_t cur_want = '0;

    logic [cse_pkg::PIX_W-1:0] older_line [cse_pkg::MAX_WIDTH];
    logic [cse_pkg::PIX_W-1:0] newer_line [cse_pkg::MAX_WIDTH];
    logic [cse_pkg::PIX_W-1:0] window [6];
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [cse_pkg::CFG_W-1:0] width_reg;
    logic [cse_pkg::CFG_W-1:0] height_reg;

    cse_pkg::edge_out_t awaited_edges [$];

    int     fail_count  = 0;
    int     pixels_in   = 0;
    int     edges_out   = 0;
    int     reg_writes  = 0;
    longint cycle_count = 0;
    bit     send_burst  = 1'b0;
    bit     pop_burst   = 1'b0;
    int     pop_hold    = 0;

    compass_sobel_edge_rgb_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [cse_pkg::CFG_W-1:0] v,
                                              input int unsigned hi);
        if (v < cse_pkg::DIM_MIN)
        begin
            return int'(cse_pkg::DIM_MIN);
        end
        if (v > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    function automatic logic [cse_pkg::CH_W-1:0] channel_strength(
        input logic [8:0][cse_pkg::PIX_W-1:0] taps,
        input int sh
    );
        int                        best;
        int                        acc;
        logic [cse_pkg::PIX_W-1:0] p;
        best = 0;
        for (int k = 0; k < 4; k++)
        begin
            acc = 0;
            for (int t = 0; t < 9; t++)
            begin
                p = taps[t];
                acc += COMPASS_K[k][t] * int'(p[sh +: cse_pkg::CH_W]);
            end
            if (acc < 0)
            begin
                acc = -acc;
            end
            if (acc > best)
            begin
                best = acc;
            end
        end
        if (best > 255)
        begin
            best = 255;
        end
        return cse_pkg::CH_W'(best);
    endfunction

    task automatic clear_edge_state();
        width_reg  = cse_pkg::LINE_WIDTH_RESET;
        height_reg = cse_pkg::FRAME_HEIGHT_RESET;
        for (int i = 0; i < cse_pkg::MAX_WIDTH; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int i = 0; i < 6; i++)
        begin
            window[i] = '0;
        end
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic predict_pixel(input cse_pkg::pixel_in_t item, output bit produced,
                                 output cse_pkg::edge_out_t res);
        int unsigned                    w;
        int unsigned                    h;
        int unsigned                    c;
        logic [cse_pkg::COL_W-1:0]      ci;
        logic [cse_pkg::PIX_W-1:0]      top;
        logic [cse_pkg::PIX_W-1:0]      mid;
        logic [8:0][cse_pkg::PIX_W-1:0] taps;
        bit                             row_end;
        w = clamp_dim(width_reg, cse_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, cse_pkg::MAX_HEIGHT);
        if (item.start_of_frame)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c        = col_pos;
        ci       = c[cse_pkg::COL_W-1:0];
        top      = older_line[ci];
        mid      = newer_line[ci];
        row_end  = (c >= w - 1);
        produced = (row_pos >= 2) && (c >= 2);
        res      = '0;
        if (produced)
        begin
            taps = {item.pixel_rgb, window[5], window[4], mid, window[3], window[2],
                    top, window[1], window[0]};
            res.edge_rgb      = {channel_strength(taps, 16), channel_strength(taps, 8),
                                 channel_strength(taps, 0)};
            res.last_in_row   = row_end;
            res.last_of_frame = row_end && (row_pos >= h - 1);
        end
        older_line[ci] = mid;
        newer_line[ci] = item.pixel_rgb;
        window[0] = window[1];
        window[1] = top;
        window[2] = window[3];
        window[3] = mid;
        window[4] = window[5];
        window[5] = item.pixel_rgb;
        if (row_end)
        begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    function automatic void apply_reg_write(input logic [cse_pkg::IDX_W-1:0] idx,
                                            input logic [cse_pkg::CFG_W-1:0] data);
        if (idx == cse_pkg::REG_LINE_WIDTH)
        begin
            width_reg = data;
        end
        else if (idx == cse_pkg::REG_FRAME_HEIGHT)
        begin
            height_reg = data;
        end
    endfunction

    function automatic int gap_length(input bit burst);
        int r;
        if (burst)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [cse_pkg::PIX_W-1:0] random_pixel();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 3))
            0, 1: return r[cse_pkg::PIX_W-1:0];
            2: return {{8{r[0]}}, {8{r[1]}}, {8{r[2]}}};
            default: return {8'($urandom_range(96, 112)), 8'($urandom_range(96, 112)),
                             8'($urandom_range(96, 112))};
        endcase
    endfunction

    function automatic logic [cse_pkg::CFG_W-1:0] pick_width();
        if ($urandom_range(0, 15) == 0)
        begin
            return cse_pkg::CFG_W'($urandom_range(0, 2));
        end
        return cse_pkg::CFG_W'($urandom_range(3, 12));
    endfunction

    function automatic logic [cse_pkg::CFG_W-1:0] pick_height();
        if ($urandom_range(0, 15) == 0)
        begin
            return cse_pkg::CFG_W'($urandom_range(0, 2));
        end
        return cse_pkg::CFG_W'($urandom_range(3, 6));
    endfunction

    // predict and check every transaction on both sides
    always @(posedge clk)
    begin
        bit                 produced;
        cse_pkg::edge_out_t predicted;
        cse_pkg::edge_out_t want;
        cycle_count++;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_reg_write(cfg_index, cfg_data);
                reg_writes++;
            end
            if (push && !full)
            begin
                predict_pixel(sample, produced, predicted);
                pixels_in++;
                if (cur_kind == CHK_VALUE)
                begin
                    awaited_edges.push_back(cur_want);
                end
                else if (cur_kind == CHK_PREDICT && produced)
                begin
                    awaited_edges.push_back(predicted);
                end
            end
            if (pop && !empty)
            begin
                edges_out++;
                if (awaited_edges.size() == 0)
                begin
                    $error("unexpected result: edge_rgb %h", result.edge_rgb);
                    fail_count++;
                end
                else
                begin
                    want = awaited_edges.pop_front();
                    if (result.edge_rgb !== want.edge_rgb)
                    begin
                        $error("edge_rgb: expected %h, got %h", want.edge_rgb, result.edge_rgb);
                        fail_count++;
                    end
                    if (result.last_in_row !== want.last_in_row)
                    begin
                        $error("last_in_row: expected %0b, got %0b",
                               want.last_in_row, result.last_in_row);
                        fail_count++;
                    end
                    if (result.last_of_frame !== want.last_of_frame)
                    begin
                        $error("last_of_frame: expected %0b, got %0b",
                               want.last_of_frame, result.last_of_frame);
                        fail_count++;
                    end
                end
            end
        end
    end

    // stall the result side at random, with stretches of back-to-back pops
    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold = pop_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 255) == 0)
            begin
                pop_burst = !pop_burst;
            end
            if (!pop_burst && $urandom_range(0, 5) == 0)
            begin
                pop_hold = gap_length(1'b0);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("[compass_sobel_edge_rgb_top] ERROR");
        $finish;
    end

    task automatic send_pixel(input logic [cse_pkg::PIX_W-1:0] px, input logic sof,
                              input check_kind_t kind, input cse_pkg::edge_out_t want);
        int g;
        if ($urandom_range(0, 127) == 0)
        begin
            send_burst = !send_burst;
        end
        g = gap_length(send_burst);
        repeat (g)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push     <= 1'b1;
        sample   <= '{pixel_rgb: px, start_of_frame: sof};
        cur_kind <= kind;
        cur_want <= want;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_run(input int count, input bit sof_first, input bit noisy);
        logic sof;
        for (int i = 0; i < count; i++)
        begin
            sof = (i == 0) ? sof_first : (noisy && $urandom_range(0, 63) == 0);
            send_pixel(random_pixel(), sof, CHK_PREDICT, '0);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (awaited_edges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cse_pkg::IDX_W-1:0] idx,
                             input logic [cse_pkg::CFG_W-1:0] data);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned               w;
        int unsigned               h;
        int                        choice;
        int                        rand_sent;
        int                        spin;
        logic [cse_pkg::CFG_W-1:0] wv;
        logic [cse_pkg::CFG_W-1:0] hv;
        clear_edge_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset dimensions: start of the first row, no results yet
        send_run(40, 1'b1, 1'b0);

        write_reg(8'hFF, 13'h0AAA);
        write_reg(cse_pkg::REG_LINE_WIDTH, 13'd0);
        write_reg(cse_pkg::REG_FRAME_HEIGHT, 13'd2);
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_pixel(DIRECTED[i].px, DIRECTED[i].sof, DIRECTED[i].kind,
                       '{edge_rgb: DIRECTED[i].want_rgb, last_in_row: DIRECTED[i].want_row,
                         last_of_frame: DIRECTED[i].want_frame});
        end

        // shrink width, then height, in the middle of a frame
        write_reg(cse_pkg::REG_LINE_WIDTH, 13'd10);
        write_reg(cse_pkg::REG_FRAME_HEIGHT, 13'd6);
        send_run(27, 1'b1, 1'b0);
        write_reg(cse_pkg::REG_LINE_WIDTH, 13'd4);
        send_run(9, 1'b0, 1'b0);
        write_reg(cse_pkg::REG_FRAME_HEIGHT, 13'd3);
        send_run(6, 1'b0, 1'b0);

        rand_sent = 0;
        while (rand_sent < RAND_PIXELS)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 7 || choice == 9)
            begin
                if (choice == 9)
                begin
                    write_reg(cse_pkg::IDX_W'($urandom_range(2, 255)),
                              cse_pkg::CFG_W'($urandom()));
                end
                wv = pick_width();
                hv = pick_height();
                if ($urandom_range(0, 1))
                begin
                    write_reg(cse_pkg::REG_LINE_WIDTH, wv);
                    write_reg(cse_pkg::REG_FRAME_HEIGHT, hv);
                end
                else
                begin
                    write_reg(cse_pkg::REG_FRAME_HEIGHT, hv);
                    write_reg(cse_pkg::REG_LINE_WIDTH, wv);
                end
                w = clamp_dim(wv, cse_pkg::MAX_WIDTH);
                h = clamp_dim(hv, cse_pkg::MAX_HEIGHT);
                send_run(w * h, 1'b1, 1'b1);
                rand_sent += w * h;
            end
            else
            begin
                w = clamp_dim(width_reg, cse_pkg::MAX_WIDTH);
                h = clamp_dim(height_reg, cse_pkg::MAX_HEIGHT);
                if (choice == 7)
                begin
                    send_run(w * h, 1'b0, 1'b1);
                    rand_sent += w * h;
                end
                else
                begin
                    spin = $urandom_range(1, w * h - 1);
                    send_run(spin, 1'($urandom_range(0, 1)), 1'b1);
                    rand_sent += spin;
                end
            end
        end

        // widest rows, then the tallest frame
        write_reg(cse_pkg::REG_LINE_WIDTH, 13'h1FFF);
        write_reg(cse_pkg::REG_FRAME_HEIGHT, 13'd3);
        send_run(24, 1'b1, 1'b0);
        write_reg(cse_pkg::REG_LINE_WIDTH, 13'd3);
        write_reg(cse_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        send_run(36, 1'b1, 1'b0);

        @(negedge clk);
        push <= 1'b0;
        spin = 0;
        while (awaited_edges.size() != 0 && spin < 10000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (16) @(posedge clk);
        if (awaited_edges.size() != 0)
        begin
            $error("%0d expected results never arrived", awaited_edges.size());
            fail_count++;
        end

        $display("covered %0d pixels, %0d edge results, %0d register writes in %0d cycles",
                 pixels_in, edges_out, reg_writes, cycle_count);
        $display("sizes: reset, clamped minimum, mid-frame shrink, random, widest, tallest");
        if (fail_count == 0)
        begin
            $display("[compass_sobel_edge_rgb_top] OK");
        end
        else
        begin
            $display("[compass_sobel_edge_rgb_top] ERROR");
        end
        $finish;
    end

endmodule
